FILE: rtl/core/avd_pkg.sv
`default_nettype none

package avd_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE         = 2'd0,
        CFG_CAESAR_SHIFT = 2'd1,
        CFG_KEY_LENGTH   = 2'd2,
        CFG_KEY_LETTERS  = 2'd3
    } t_cfg_index;

    localparam int CHAR_W    = 8;
    localparam int SHIFT_W   = 10;
    localparam int KLEN_W    = 4;
    localparam int LETTER_W  = 5;
    localparam int KEY_SLOTS = 10;
    localparam int KEYS_W    = LETTER_W * KEY_SLOTS;

    localparam logic [CHAR_W-1:0] CH_0_LO = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_0_HI = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CH_A_HI = 8'h7A;  // 'z'
    localparam logic [CHAR_W-1:0] CH_U_LO = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_U_HI = 8'h5A;  // 'Z'

    localparam logic [5:0] MOD_DIGIT  = 6'd10;
    localparam logic [5:0] MOD_LETTER = 6'd26;

    // Shift split as s = hi*32 + lo. Tables give (hi*32) mod N and lo mod 10.
    localparam logic [4:0] MOD26_HI [32] = '{
        5'd0,  5'd6,  5'd12, 5'd18, 5'd24, 5'd4,  5'd10, 5'd16,
        5'd22, 5'd2,  5'd8,  5'd14, 5'd20, 5'd0,  5'd6,  5'd12,
        5'd18, 5'd24, 5'd4,  5'd10, 5'd16, 5'd22, 5'd2,  5'd8,
        5'd14, 5'd20, 5'd0,  5'd6,  5'd12, 5'd18, 5'd24, 5'd4
    };

    localparam logic [3:0] MOD10_HI [32] = '{
        4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd0, 4'd2, 4'd4,
        4'd6, 4'd8, 4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd0,
        4'd2, 4'd4, 4'd6, 4'd8, 4'd0, 4'd2, 4'd4, 4'd6,
        4'd8, 4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd0, 4'd2
    };

    localparam logic [3:0] MOD10_LO [32] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
        4'd6, 4'd7, 4'd8, 4'd9, 4'd0, 4'd1, 4'd2, 4'd3,
        4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd0, 4'd1
    };

    // (off - m) mod modulus, with off, m already below modulus
    function automatic logic [4:0] f_wrap_down(
        input logic [4:0] off,
        input logic [4:0] m,
        input logic [5:0] modulus
    );
        logic [5:0] t;
        t = {1'b0, off} + (modulus - {1'b0, m});
        if (t >= modulus) begin
            t = t - modulus;
        end
        return t[4:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/alnum_vigenere_decrypt.sv
`default_nettype none

// Channel   | Dir | Handshake                     | Payload
// ----------+-----+-------------------------------+-----------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] in_char, tlast end_of_text
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata[7:0] out_char, tlast last
// cfg       | in  | i_cfg_wr_en (no wait)         | i_cfg_index, i_cfg_wdata[49:0]
//
// One byte per clock unless m_axis stalls; m_axis_tvalid is driven by the output register.
// Stage 1 registers the byte and its key shift (key position counter updates here);
// stage 2 reduces the shift mod 10 / 26 by table lookup and decodes into the output register.
// Reset (i_rst_n low, synchronous) empties both stages, clears key position, config to defaults.
// A stall on m_axis backs up through stage 1; s_axis_tready drops only when both are full.

module alnum_vigenere_decrypt #(
    parameter int KEY_MAX_LEN = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_char
    input  wire logic        s_axis_tlast,   // end_of_text
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_char
    output logic             m_axis_tlast,   // last
    // config write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [49:0] i_cfg_wdata
);

    localparam logic [avd_pkg::KLEN_W-1:0] MAX_LEN = avd_pkg::KLEN_W'(KEY_MAX_LEN);
    localparam logic [avd_pkg::KLEN_W-1:0] SLOTS   = avd_pkg::KLEN_W'(avd_pkg::KEY_SLOTS);

    // ---------------- configuration registers ----------------
    logic                             r_mode;
    logic [avd_pkg::SHIFT_W-1:0]      r_caesar_shift;
    logic [avd_pkg::KLEN_W-1:0]       r_key_length;
    logic [avd_pkg::KEYS_W-1:0]       r_key_letters;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= 1'b0;
            r_caesar_shift <= '0;
            r_key_length   <= avd_pkg::KLEN_W'(1);
            r_key_letters  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (avd_pkg::t_cfg_index'(i_cfg_index))
                avd_pkg::CFG_MODE:         r_mode         <= i_cfg_wdata[0];
                avd_pkg::CFG_CAESAR_SHIFT: r_caesar_shift <= i_cfg_wdata[avd_pkg::SHIFT_W-1:0];
                avd_pkg::CFG_KEY_LENGTH:   r_key_length   <= i_cfg_wdata[avd_pkg::KLEN_W-1:0];
                avd_pkg::CFG_KEY_LETTERS:  r_key_letters  <= i_cfg_wdata[avd_pkg::KEYS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake / stage control ----------------
    logic r_v1;          // stage 1 holds a transaction
    logic r_m_valid;     // output register holds a transaction
    logic adv1;          // stage 1 may move into the output register
    logic s_accept;

    assign adv1          = !r_m_valid || m_axis_tready;
    assign s_axis_tready = !r_v1 || adv1;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // ---------------- key position and shift select ----------------
    logic [avd_pkg::KLEN_W-1:0]   r_key_position;
    logic [avd_pkg::KLEN_W-1:0]   eff_len;
    logic [avd_pkg::KLEN_W-1:0]   pos_eff;
    logic [avd_pkg::KLEN_W-1:0]   pos_inc;
    logic [avd_pkg::KLEN_W-1:0]   n_key_position;
    logic [avd_pkg::LETTER_W-1:0] key_slot [avd_pkg::KEY_SLOTS];
    logic [avd_pkg::LETTER_W-1:0] key_letter;
    logic [avd_pkg::SHIFT_W-1:0]  shift_sel;

    always_comb begin
        for (int i = 0; i < avd_pkg::KEY_SLOTS; i++) begin
            key_slot[i] = r_key_letters[avd_pkg::LETTER_W*i +: avd_pkg::LETTER_W];
        end
    end

    always_comb begin
        // zero length acts as one, long lengths saturate
        eff_len = r_key_length;
        if (eff_len == '0) begin
            eff_len = avd_pkg::KLEN_W'(1);
        end
        if (eff_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end

        // length lowered mid-message: restart at the first letter
        pos_eff = (r_key_position >= eff_len) ? '0 : r_key_position;

        // slots past the key register read as zero shift
        key_letter = (pos_eff < SLOTS) ? key_slot[pos_eff] : '0;
        shift_sel  = r_mode ? avd_pkg::SHIFT_W'(key_letter) : r_caesar_shift;

        pos_inc        = pos_eff + avd_pkg::KLEN_W'(1);
        n_key_position = (pos_inc >= eff_len || s_axis_tlast) ? '0 : pos_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_position <= '0;
        end else if (s_accept) begin
            r_key_position <= n_key_position;
        end
    end

    // ---------------- stage 1 register ----------------
    logic [avd_pkg::CHAR_W-1:0]  r_char;
    logic                        r_eot;
    logic [avd_pkg::SHIFT_W-1:0] r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_axis_tready) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_char  <= s_axis_tdata;
            r_eot   <= s_axis_tlast;
            r_shift <= shift_sel;
        end
    end

    // ---------------- stage 2: reduce shift, decode byte ----------------
    logic [4:0]                 sh_hi;
    logic [4:0]                 sh_lo;
    logic [5:0]                 m26_sum;
    logic [4:0]                 m26;
    logic [4:0]                 m10_sum;
    logic [4:0]                 m10;
    logic [4:0]                 lo26;
    logic                       is_digit;
    logic                       is_lower;
    logic                       is_upper;
    logic [avd_pkg::CHAR_W-1:0] dec_char;
    logic [avd_pkg::CHAR_W-1:0] off_digit;
    logic [avd_pkg::CHAR_W-1:0] off_lower;
    logic [avd_pkg::CHAR_W-1:0] off_upper;

    always_comb begin
        sh_hi = r_shift[9:5];
        sh_lo = r_shift[4:0];

        lo26    = (sh_lo >= 5'd26) ? sh_lo - 5'd26 : sh_lo;
        m26_sum = {1'b0, avd_pkg::MOD26_HI[sh_hi]} + {1'b0, lo26};
        m26     = (m26_sum >= avd_pkg::MOD_LETTER) ? 5'(m26_sum - avd_pkg::MOD_LETTER)
                                                   : m26_sum[4:0];

        m10_sum = {1'b0, avd_pkg::MOD10_HI[sh_hi]} + {1'b0, avd_pkg::MOD10_LO[sh_lo]};
        m10     = (m10_sum >= 5'd10) ? m10_sum - 5'd10 : m10_sum;

        is_digit = (r_char >= avd_pkg::CH_0_LO) && (r_char <= avd_pkg::CH_0_HI);
        is_lower = (r_char >= avd_pkg::CH_A_LO) && (r_char <= avd_pkg::CH_A_HI);
        is_upper = (r_char >= avd_pkg::CH_U_LO) && (r_char <= avd_pkg::CH_U_HI);

        off_digit = r_char - avd_pkg::CH_0_LO;
        off_lower = r_char - avd_pkg::CH_A_LO;
        off_upper = r_char - avd_pkg::CH_U_LO;

        if (is_digit) begin
            dec_char = avd_pkg::CH_0_LO + avd_pkg::CHAR_W'(
                avd_pkg::f_wrap_down(off_digit[4:0], m10, avd_pkg::MOD_DIGIT));
        end else if (is_lower) begin
            dec_char = avd_pkg::CH_A_LO + avd_pkg::CHAR_W'(
                avd_pkg::f_wrap_down(off_lower[4:0], m26, avd_pkg::MOD_LETTER));
        end else if (is_upper) begin
            dec_char = avd_pkg::CH_U_LO + avd_pkg::CHAR_W'(
                avd_pkg::f_wrap_down(off_upper[4:0], m26, avd_pkg::MOD_LETTER));
        end else begin
            dec_char = r_char;   // not alphanumeric: pass through
        end
    end

    // ---------------- output register ----------------
    logic [avd_pkg::CHAR_W-1:0] r_out_char;
    logic                       r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv1) begin
            r_m_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_v1) begin
            r_out_char <= dec_char;
            r_out_last <= r_eot;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_pos_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_key_position < $past(eff_len)))
        else $error("key position not below effective key length");

    a_pos_clear_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tlast) |=> (r_key_position == '0))
        else $error("key position not cleared after end of text");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_m_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv1 && !is_digit && !is_lower && !is_upper)
            |=> (m_axis_tdata == $past(r_char)))
        else $error("non-alphanumeric byte altered");

endmodule

`default_nettype wire
